>>> rtl/arm26_integer_execute_macros.svh
// Assertion macros for the 26-bit integer execute block
`ifndef ARM26_INTEGER_EXECUTE_MACROS_SVH
`define ARM26_INTEGER_EXECUTE_MACROS_SVH
// same-cycle implication
`define A26X_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define A26X_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/a26x_pkg.sv
// Package: types, opcodes and helper functions of the 26-bit integer execute block
`timescale 1ns / 1ps
package a26x_pkg;
    localparam int ADDR_BITS_DEFAULT = 26;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [15:0] LOGIC_OPS = 16'hf303;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] REG_PC = 4'd15;
    localparam logic [3:0] REG_LR = 4'd14;

    typedef struct packed {
        logic [31:0] instruction;
        logic        is_mul;
        logic        is_branch;
        logic        is_dp;
        logic        unsupported;
    } dec_t;

    typedef struct packed {
        logic        executed;
        logic        unsupported;
        logic        dest_valid;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic [3:0]  flags_out;
        logic [25:0] next_pc;
    } res_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} >> n;
        return w[31:0];
    endfunction

    function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
        logic n, z, c, v, p;
        n = f[3];
        z = f[2];
        c = f[1];
        v = f[0];
        case (cond)
            4'd0:    p = z;
            4'd1:    p = !z;
            4'd2:    p = c;
            4'd3:    p = !c;
            4'd4:    p = n;
            4'd5:    p = !n;
            4'd6:    p = v;
            4'd7:    p = !v;
            4'd8:    p = c && !z;
            4'd9:    p = !c || z;
            4'd10:   p = n == v;
            4'd11:   p = n != v;
            4'd12:   p = !z && (n == v);
            4'd13:   p = z || (n != v);
            4'd14:   p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction
endpackage

>>> rtl/arm26_integer_execute.sv
// Top level of the 26-bit integer execute block
//
// Instruction requests enter through push/full: a request is taken at a clock
// edge with push high and full low. A two-entry queue holds classified words.
// The back end retires one instruction per cycle against r0..r14, the PC and
// the NZCV flags; shifter, ALU and multiplier work completes in that cycle.
// Results leave through empty/pop: the oldest result is on the ports while
// empty is low and is taken at an edge with pop high.
// A request is written into the front queue, then executed into the result
// queue. Throughput: one instruction per cycle with pop held high.
// When pop stays low the result queue fills after two results, the back end
// holds, the front queue fills and full rises two requests later.
// Reset clears both queues, all registers, the PC and the flags at once.
`timescale 1ns / 1ps
module arm26_integer_execute #(
    parameter int ADDRESS_BITS = a26x_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [31:0]             instruction,
    output logic                    empty,
    input  logic                    pop,
    output logic                    executed,
    output logic                    unsupported,
    output logic                    dest_valid,
    output logic [3:0]              dest_index,
    output logic [31:0]             dest_value,
    output logic [3:0]              flags_out,
    output logic [ADDRESS_BITS-1:0] next_pc
);
    import a26x_pkg::*;

    logic dec_valid, dec_take;
    dec_t dec_data;
    res_t res_data;

    a26x_front u_front (
        .clk, .rst_n, .push, .full, .instruction,
        .dec_valid, .dec_data, .dec_take
    );

    a26x_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
        .clk, .rst_n, .dec_valid, .dec_data, .dec_take,
        .empty, .pop, .res_data
    );

    assign executed    = res_data.executed;
    assign unsupported = res_data.unsupported;
    assign dest_valid  = res_data.dest_valid;
    assign dest_index  = res_data.dest_index;
    assign dest_value  = res_data.dest_value;
    assign flags_out   = res_data.flags_out;
    assign next_pc     = ADDRESS_BITS'(res_data.next_pc);
endmodule

>>> rtl/a26x_front.sv
// Front end: accept, classify and queue instruction requests
`timescale 1ns / 1ps
module a26x_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        instruction,
    output logic               dec_valid,
    output a26x_pkg::dec_t     dec_data,
    input  logic               dec_take
);
    import a26x_pkg::*;

    dec_t       q_reg [0:1];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    dec_t       d;
    logic       wr, rd;

    always_comb
    begin
        d.instruction = instruction;
        d.is_mul      = (instruction & 32'h0FC000F0) == 32'h00000090;
        d.is_branch   = instruction[27:25] == 3'd5;
        d.is_dp       = instruction[27:26] == 2'd0 && !d.is_mul
                        && (instruction & 32'h02000090) != 32'h00000090;
        d.unsupported = !(d.is_mul || d.is_branch || d.is_dp);
    end

    assign full      = cnt_reg == 2'd2;
    assign dec_valid = cnt_reg != 2'd0;
    assign dec_data  = q_reg[rp_reg];
    assign wr        = push && !full;
    assign rd        = dec_take && dec_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

>>> rtl/a26x_back.sv
// Back end: register file, shifter, ALU, multiplier and result queue
`timescale 1ns / 1ps
module a26x_back #(
    parameter int ADDRESS_BITS = a26x_pkg::ADDR_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               dec_valid,
    input  a26x_pkg::dec_t     dec_data,
    output logic               dec_take,
    output logic               empty,
    input  logic               pop,
    output a26x_pkg::res_t     res_data
);
    import a26x_pkg::*;

    logic [31:0]             regs_reg [0:14];
    logic [ADDRESS_BITS-1:0] pc_reg, pc_next;
    logic [3:0]              flags_reg, flags_next;
    res_t                    oq_reg [0:1];
    logic                    owp_reg, orp_reg;
    logic [1:0]              ocnt_reg;

    logic [31:0] ins;
    logic [ADDRESS_BITS-1:0] pc4, pc8, pc12, pcoff;
    logic [31:0] rn_v, rm_v, rs_v, ra_v, op2, res, a, b, mul_p;
    logic [32:0] sum;
    logic        cin, sc, cflag, cv_c, cv_v, logic_op, ofull, take;
    logic [3:0]  op, rdi;
    logic [7:0]  n8;
    logic [4:0]  n5;
    logic [1:0]  sht;
    logic [3:0]  nf;
    logic        wen;
    logic [3:0]  widx;
    res_t        r;

    function automatic logic [31:0] rdreg(input logic [3:0] idx, input logic [31:0] rv,
                                          input logic [ADDRESS_BITS-1:0] pcv,
                                          input logic psr, input logic [3:0] f);
        logic [31:0] v;
        v = 32'(pcv);
        if (psr)
        begin
            v[31:28] = f;
        end
        return (idx == REG_PC) ? v : rv;
    endfunction

    assign ins   = dec_data.instruction;
    assign cflag = flags_reg[1];
    assign pc4   = pc_reg + ADDRESS_BITS'(4);
    assign pc8   = pc_reg + ADDRESS_BITS'(8);
    assign pc12  = pc_reg + ADDRESS_BITS'(12);
    assign pcoff = (!ins[25] && ins[4] && dec_data.is_dp) ? pc12 : pc8;
    assign ofull = ocnt_reg == 2'd2;
    assign take  = dec_valid && !ofull;
    assign dec_take = take;

    always_comb
    begin
        rn_v = rdreg(ins[19:16], (ins[19:16] == REG_PC) ? 32'd0 : regs_reg[ins[19:16]],
                     pcoff, 1'b0, flags_reg);
        rm_v = rdreg(ins[3:0], (ins[3:0] == REG_PC) ? 32'd0 : regs_reg[ins[3:0]],
                     pcoff, 1'b1, flags_reg);
        rs_v = rdreg(ins[11:8], (ins[11:8] == REG_PC) ? 32'd0 : regs_reg[ins[11:8]],
                     pcoff, 1'b1, flags_reg);
        ra_v = rdreg(ins[15:12], (ins[15:12] == REG_PC) ? 32'd0 : regs_reg[ins[15:12]],
                     pc8, 1'b1, flags_reg);
    end

    always_comb
    begin
        sht = ins[6:5];
        n8  = rs_v[7:0];
        n5  = ins[11:7];
        op2 = rm_v;
        sc  = cflag;
        if (ins[25])
        begin
            op2 = rotr({24'd0, ins[7:0]}, {ins[11:8], 1'b0});
            if (ins[11:8] != 4'd0)
            begin
                sc = op2[31];
            end
        end
        else if (ins[4])
        begin
            if (n8 != 8'd0)
            begin
                case (sht)
                    SH_LSL:
                    begin
                        op2 = (n8 < 8'd32) ? rm_v << n8[4:0] : 32'd0;
                        sc  = (n8 < 8'd32) ? rm_v[5'(6'd32 - {1'b0, n8[4:0]})]
                              : ((n8 == 8'd32) ? rm_v[0] : 1'b0);
                    end
                    SH_LSR:
                    begin
                        op2 = (n8 < 8'd32) ? rm_v >> n8[4:0] : 32'd0;
                        sc  = (n8 < 8'd32) ? rm_v[5'(n8[4:0] - 5'd1)]
                              : ((n8 == 8'd32) ? rm_v[31] : 1'b0);
                    end
                    SH_ASR:
                    begin
                        op2 = (n8 < 8'd32) ? 32'($signed(rm_v) >>> n8[4:0])
                              : {32{rm_v[31]}};
                        sc  = (n8 < 8'd32) ? rm_v[5'(n8[4:0] - 5'd1)] : rm_v[31];
                    end
                    default:
                    begin
                        op2 = rotr(rm_v, n8[4:0]);
                        sc  = rm_v[5'(n8[4:0] - 5'd1)];
                    end
                endcase
            end
        end
        else
        begin
            case (sht)
                SH_LSL:
                begin
                    if (n5 != 5'd0)
                    begin
                        op2 = rm_v << n5;
                        sc  = rm_v[5'(6'd32 - {1'b0, n5})];
                    end
                end
                SH_LSR:
                begin
                    op2 = (n5 != 5'd0) ? rm_v >> n5 : 32'd0;
                    sc  = rm_v[(n5 != 5'd0) ? 5'(n5 - 5'd1) : 5'd31];
                end
                SH_ASR:
                begin
                    op2 = (n5 != 5'd0) ? 32'($signed(rm_v) >>> n5) : {32{rm_v[31]}};
                    sc  = rm_v[(n5 != 5'd0) ? 5'(n5 - 5'd1) : 5'd31];
                end
                default:
                begin
                    if (n5 == 5'd0)
                    begin
                        op2 = {cflag, rm_v[31:1]};
                        sc  = rm_v[0];
                    end
                    else
                    begin
                        op2 = rotr(rm_v, n5);
                        sc  = rm_v[5'(n5 - 5'd1)];
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        op  = ins[24:21];
        a   = rn_v;
        b   = op2;
        cin = 1'b0;
        case (op)
            OP_SUB, OP_CMP: begin a = rn_v; b = ~op2; cin = 1'b1;  end
            OP_RSB:         begin a = op2;  b = ~rn_v; cin = 1'b1; end
            OP_ADC:         begin a = rn_v; b = op2;  cin = cflag; end
            OP_SBC:         begin a = rn_v; b = ~op2; cin = cflag; end
            OP_RSC:         begin a = op2;  b = ~rn_v; cin = cflag; end
            default:        begin a = rn_v; b = op2;  cin = 1'b0;  end
        endcase
        sum  = {1'b0, a} + {1'b0, b} + 33'(cin);
        cv_c = sum[32];
        cv_v = ((a ^ sum[31:0]) & (b ^ sum[31:0])) >> 31 != 32'd0;
        case (op)
            OP_AND, OP_TST: res = rn_v & op2;
            OP_EOR, OP_TEQ: res = rn_v ^ op2;
            OP_ORR:         res = rn_v | op2;
            OP_MOV:         res = op2;
            OP_BIC:         res = rn_v & ~op2;
            OP_MVN:         res = ~op2;
            default:        res = sum[31:0];
        endcase
        logic_op = LOGIC_OPS[op];
        nf = {res[31], res == 32'd0, logic_op ? sc : cv_c, logic_op ? flags_reg[0] : cv_v};
    end

    assign mul_p = rm_v * rs_v;

    always_comb
    begin
        rdi        = ins[15:12];
        pc_next    = pc4;
        flags_next = flags_reg;
        wen        = 1'b0;
        widx       = 4'd0;
        r.executed    = 1'b0;
        r.unsupported = dec_data.unsupported;
        r.dest_valid  = 1'b0;
        r.dest_index  = 4'd0;
        r.dest_value  = 32'd0;
        if (!dec_data.unsupported && cond_pass(ins[31:28], flags_reg))
        begin
            r.executed = 1'b1;
            if (dec_data.is_dp)
            begin
                if (op >= OP_TST && op <= OP_CMN)
                begin
                    if (ins[20])
                    begin
                        flags_next = (rdi == REG_PC) ? res[31:28] : nf;
                    end
                end
                else if (rdi == REG_PC)
                begin
                    pc_next      = {res[ADDRESS_BITS-1:2], 2'b00};
                    r.dest_valid = 1'b1;
                    r.dest_index = REG_PC;
                    r.dest_value = 32'({res[ADDRESS_BITS-1:2], 2'b00});
                    if (ins[20])
                    begin
                        flags_next = res[31:28];
                    end
                end
                else
                begin
                    wen          = 1'b1;
                    widx         = rdi;
                    r.dest_valid = 1'b1;
                    r.dest_index = rdi;
                    r.dest_value = res;
                    if (ins[20])
                    begin
                        flags_next = nf;
                    end
                end
            end
            else if (dec_data.is_branch)
            begin
                if (ins[24])
                begin
                    wen          = 1'b1;
                    widx         = REG_LR;
                    r.dest_valid = 1'b1;
                    r.dest_index = REG_LR;
                    r.dest_value = {flags_reg, 28'(pc4)};
                end
                pc_next = pc8 + ADDRESS_BITS'({ins[23:0], 2'b00});
            end
            else
            begin
                r.dest_value = ins[21] ? mul_p + ra_v : mul_p;
                if (ins[19:16] != REG_PC)
                begin
                    wen          = 1'b1;
                    widx         = ins[19:16];
                    r.dest_valid = 1'b1;
                    r.dest_index = ins[19:16];
                end
                else
                begin
                    r.dest_value = 32'd0;
                end
                if (ins[20])
                begin
                    flags_next = {(ins[21] ? mul_p + ra_v : mul_p) >> 31 != 32'd0,
                                  (ins[21] ? mul_p + ra_v : mul_p) == 32'd0,
                                  flags_reg[1:0]};
                end
            end
        end
        r.flags_out = flags_next;
        r.next_pc   = 26'(pc_next);
    end

    assign empty    = ocnt_reg == 2'd0;
    assign res_data = oq_reg[orp_reg];

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            oq_reg[owp_reg] <= r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 15; i++)
            begin
                regs_reg[i] <= 32'd0;
            end
            pc_reg    <= '0;
            flags_reg <= 4'd0;
            owp_reg   <= 1'b0;
            orp_reg   <= 1'b0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                pc_reg    <= pc_next;
                flags_reg <= flags_next;
                owp_reg   <= !owp_reg;
                if (wen)
                begin
                    regs_reg[widx] <= r.dest_value;
                end
            end
            if (pop && !empty)
            begin
                orp_reg <= !orp_reg;
            end
            ocnt_reg <= ocnt_reg + 2'(take) - 2'(pop && !empty);
        end
    end
endmodule

>>> rtl/a26x_checker.sv
// Port checker of the 26-bit integer execute block, with its bind
`timescale 1ns / 1ps
`include "arm26_integer_execute_macros.svh"
module a26x_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        executed,
    input logic        unsupported,
    input logic        dest_valid,
    input logic [3:0]  dest_index,
    input logic [31:0] dest_value,
    input logic [25:0] next_pc
);
    `A26X_ASSERT_NOW(a_exec_supported, clk, rst_n, !empty, !(executed && unsupported), "unsupported result marked executed")
    `A26X_ASSERT_NOW(a_pc_aligned, clk, rst_n, !empty, next_pc[1:0] == 2'b00, "next_pc not word aligned")
    `A26X_ASSERT_NOW(a_no_dest, clk, rst_n, !empty && !dest_valid, dest_index == 4'd0 && dest_value == 32'd0, "dest fields set without write")
    `A26X_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty, "result dropped while not popped")
endmodule

bind arm26_integer_execute a26x_checker u_checker (
    .clk, .rst_n, .empty, .pop, .executed, .unsupported,
    .dest_valid, .dest_index, .dest_value, .next_pc
);
